/* rtl/flpt_pkg.sv */
// ----------------------------------------------------------------------------
// flpt_pkg
// shared types and constants of the four-level page table map unit
// ----------------------------------------------------------------------------
package flpt_pkg;

  localparam int POOL_TABLES_DEF = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W = 9;
  localparam int ENTRY_W = 64;
  localparam int RES_W = 52;

  typedef enum logic [1:0] {
    ACT_MAP       = 2'd0,
    ACT_UNMAP     = 2'd1,
    ACT_TRANSLATE = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD       = 3'd1,
    ST_NONCANON  = 3'd2,
    ST_UNMAPPED  = 3'd3,
    ST_DUP       = 3'd4,
    ST_EXHAUST   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EV,
    S_DONE
  } state_t;

  // entry bits
  localparam int E_PRESENT = 0;
  localparam int E_WRITE   = 1;
  localparam int E_USER    = 2;

  function automatic logic canonical(input logic [63:0] va);
    if (va[47]) begin
      return va[63:48] == 16'hFFFF;
    end
    return va[63:48] == 16'h0000;
  endfunction

endpackage

/* rtl/four_level_page_table_map_unit.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_map_unit
// map, unmap and translate against an internal four-level page table
// ----------------------------------------------------------------------------
// The page tables live in one single-port ram of POOL_TABLES x 512 entries.
// After reset the unit sweeps the ram to zero, one entry a cycle, and no
// beat is taken until the sweep is done. Each beat is one operation. A
// beat that fails its address checks skips the walk and goes straight to
// the answer state, which loads its status into the output register.
// Otherwise the sequencer walks the four levels, each a ram read followed
// by an evaluate cycle that may write the same entry back; the walk may
// stop before the last level. A waiting answer that the receiver stalls
// holds the sequencer in its answer cycle. One beat is worked on at a
// time; the next is taken while the answer still waits in the output
// register. Tables are handed out from the pool in order and never freed;
// once the pool runs out a map that needs a table answers with the pool
// exhausted status.
// ----------------------------------------------------------------------------
module four_level_page_table_map_unit
  import flpt_pkg::*;
#(
  parameter int POOL_TABLES = POOL_TABLES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [63:0]       virt_addr,
  input  logic [63:0]       phys_addr,
  input  logic [4:0]        page_flags,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [RES_W-1:0]  result_addr,
  output logic [2:0]        status
);

  localparam int DEPTH = POOL_TABLES * ENTRIES_PER_TABLE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW - IDX_W;              // table number width
  localparam int FW    = $clog2(POOL_TABLES + 1); // free counter width

  state_t state, state_next;

  // latched operation
  action_t       act;
  logic [63:0]   va;
  logic [39:0]   pa_frame;
  logic [4:0]    fl;

  logic [1:0]    level;
  logic [TW-1:0] tbl;
  logic [FW-1:0] nfree;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] clr_cnt;
  status_t       st_q;
  logic [RES_W-1:0] res_q;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] rdata;

  flpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  // entry check of an incoming beat
  status_t pre_st;
  always_comb begin
    pre_st = ST_OK;
    case (action_t'(action))
      ACT_MAP: begin
        if (virt_addr[11:0] != 12'd0 || phys_addr[11:0] != 12'd0 ||
            phys_addr[63:52] != 12'd0 || (page_flags[0] && !page_flags[4])) begin
          pre_st = ST_BAD;
        end else if (!canonical(virt_addr)) begin
          pre_st = ST_NONCANON;
        end
      end
      ACT_UNMAP: begin
        if (virt_addr[11:0] != 12'd0) begin
          pre_st = ST_BAD;
        end else if (!canonical(virt_addr)) begin
          pre_st = ST_NONCANON;
        end
      end
      ACT_TRANSLATE: begin
        if (!canonical(virt_addr)) begin
          pre_st = ST_NONCANON;
        end
      end
      default: pre_st = ST_BAD;
    endcase
  end

  // index of the current level
  logic [IDX_W-1:0] lvl_idx;
  always_comb begin
    case (level)
      2'd0:    lvl_idx = va[47:39];
      2'd1:    lvl_idx = va[38:30];
      2'd2:    lvl_idx = va[29:21];
      default: lvl_idx = va[20:12];
    endcase
  end

  // evaluate of the entry just read
  logic               create, present, is_leaf, pool_ok, nt_ok;
  logic [ENTRY_W-1:0] tflags, new_leaf;
  status_t            ev_st;
  logic               ev_done;

  assign create  = act == ACT_MAP;
  assign present = rdata[E_PRESENT];
  assign is_leaf = level == 2'd3;
  assign pool_ok = nfree < FW'(POOL_TABLES);
  assign nt_ok   = rdata[51:12] < 40'(POOL_TABLES);
  assign tflags  = ENTRY_W'({fl[1], 2'b11});
  assign new_leaf = {fl[4], 11'd0, pa_frame, 7'd0, fl[3:0], 1'b1};

  always_comb begin
    ev_st   = ST_OK;
    ev_done = 1'b0;
    if (is_leaf) begin
      ev_done = 1'b1;
      if (create && present) begin
        ev_st = ST_DUP;
      end else if (!create && !present) begin
        ev_st = ST_UNMAPPED;
      end
    end else if (present) begin
      if (!nt_ok) begin
        ev_st   = ST_UNMAPPED;
        ev_done = 1'b1;
      end
    end else if (!create) begin
      ev_st   = ST_UNMAPPED;
      ev_done = 1'b1;
    end else if (!pool_ok) begin
      ev_st   = ST_EXHAUST;
      ev_done = 1'b1;
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_next = (pre_st == ST_OK) ? S_RD : S_DONE;
        end
      end
      S_RD:   state_next = S_EV;
      S_EV:   state_next = ev_done ? S_DONE : S_RD;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // ram control and handshake
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      S_IDLE: in_stall = 1'b0;
      S_RD:   ram_addr = {tbl, lvl_idx};
      S_EV: begin
        if (!is_leaf) begin
          if (present) begin
            ram_we    = create;
            ram_wdata = rdata | tflags;
          end else begin
            ram_we    = create && pool_ok;
            ram_wdata = (ENTRY_W'(nfree) << 12) | tflags;
          end
        end else if (create) begin
          ram_we    = !present;
          ram_wdata = new_leaf;
        end else begin
          // unmap clears the leaf, translate only reads it
          ram_we    = (act == ACT_UNMAP) && present;
          ram_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      nfree     <= FW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == S_EV && !is_leaf && !present && create && pool_ok) begin
        nfree <= nfree + FW'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act      <= action_t'(action);
        va       <= virt_addr;
        pa_frame <= phys_addr[51:12];
        fl       <= page_flags;
        level    <= 2'd0;
        tbl      <= '0;
        st_q     <= pre_st;
        res_q    <= '0;
      end
      S_RD: addr_q <= ram_addr;
      S_EV: begin
        st_q <= ev_st;
        if (is_leaf) begin
          if (act == ACT_UNMAP) begin
            res_q <= {rdata[51:12], 12'd0};
          end else begin
            res_q <= {rdata[51:12], va[11:0]};
          end
        end else begin
          level <= level + 2'd1;
          tbl   <= present ? rdata[12 +: TW] : nfree[TW-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          ok          <= st_q == ST_OK;
          status      <= st_q;
          result_addr <= (st_q == ST_OK) ? res_q : '0;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nfree <= FW'(POOL_TABLES))
    else $error("free table counter beyond pool");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (status == ST_OK)))
    else $error("ok and status disagree");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall)
    else $error("beat taken during clearing sweep");

  a_write_same_entry: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_EV) |-> ($past(state) == S_RD && ram_addr == addr_q))
    else $error("write back not at the entry just read");

endmodule

/* rtl/flpt_ram.sv */
// ----------------------------------------------------------------------------
// flpt_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module flpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
